// ===== rtl/core/srsw_pkg.sv =====
// Shared types and constants for the selective-repeat sender window.
// No dependencies; every other file in rtl/core refers to this package.
package srsw_pkg;

    localparam int WINDOW_SIZE   = 16;
    localparam int SEQ_BITS      = 16;
    localparam int TIME_BITS     = 32;
    localparam int SLOT_BITS     = $clog2(WINDOW_SIZE);
    localparam int PTR_BITS      = SLOT_BITS + 1;
    localparam int CNT_BITS      = $clog2(WINDOW_SIZE + 1);
    localparam int CFG_BITS      = 16;
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 3;

    localparam logic [CFG_BITS-1:0] TIMEOUT_RESET = 16'd6000;

    // register index, taken from paddr[2]
    localparam logic REG_TOTAL_PACKETS = 1'b0;
    localparam logic REG_TIMEOUT_TICKS = 1'b1;

    typedef enum logic [1:0] {
        OP_SEND = 2'd0,
        OP_ACK  = 2'd1,
        OP_TICK = 2'd2
    } t_opcode;

    typedef enum logic [2:0] {
        RK_NONE        = 3'd0,
        RK_SEND        = 3'd1,
        RK_RETX        = 3'd2,
        RK_ACK_TAKEN   = 3'd3,
        RK_ACK_IGNORED = 3'd4
    } t_result_kind;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEND,
        ST_ACK_CHECK,
        ST_ACK_MARK,
        ST_SLIDE,
        ST_ACK_FIN,
        ST_TICK_START,
        ST_TICK_EVAL,
        ST_TICK_DROP,
        ST_RESULT
    } t_state;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_SEND,
        DP_ACK_MARK,
        DP_SLIDE,
        DP_ACK_FIN,
        DP_TICK_START,
        DP_TICK_EVAL,
        DP_TICK_DROP,
        DP_EMIT
    } t_dp_op;

    typedef struct packed {
        logic done;
        logic in_range;
        logic slide_more;
        logic tick_go;
        logic out_free;
    } t_dp_status;

    typedef struct packed {
        logic [SEQ_BITS-1:0]  seq;
        logic [TIME_BITS-1:0] stamp;
    } t_q_entry;

endpackage

// ===== rtl/core/srsw_in_if.sv =====
// Request channel: opcode and ack sequence number with valid/ready.
// Depends on srsw_pkg.
interface srsw_in_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    opcode;
    logic [srsw_pkg::SEQ_BITS-1:0] ack_seq;

    modport source (output valid, output opcode, output ack_seq, input ready);
    modport sink   (input valid, input opcode, input ack_seq, output ready);
endinterface

// ===== rtl/core/srsw_out_if.sv =====
// Result channel: one result beat per request, valid/ready.
// Depends on srsw_pkg.
interface srsw_out_if;
    logic                          valid;
    logic                          ready;
    logic [2:0]                    result_kind;
    logic [srsw_pkg::SEQ_BITS-1:0] packet_seq;
    logic [srsw_pkg::SEQ_BITS-1:0] base_seq;
    logic [srsw_pkg::CNT_BITS-1:0] free_slots;
    logic                          all_done;

    modport source (output valid, output result_kind, output packet_seq, output base_seq,
                    output free_slots, output all_done, input ready);
    modport sink   (input valid, input result_kind, input packet_seq, input base_seq,
                    input free_slots, input all_done, output ready);
endinterface

// ===== rtl/core/srsw_apb_regs.sv =====
// APB register file: total_packets and timeout_ticks.
// Depends on srsw_pkg.
module srsw_apb_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [srsw_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [srsw_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [srsw_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready,
    output logic [srsw_pkg::CFG_BITS-1:0]       o_total_packets,
    output logic [srsw_pkg::CFG_BITS-1:0]       o_timeout_ticks
);

    logic [srsw_pkg::CFG_BITS-1:0] r_total_packets;
    logic [srsw_pkg::CFG_BITS-1:0] r_timeout_ticks;
    logic                          w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_packets <= '0;
            r_timeout_ticks <= srsw_pkg::TIMEOUT_RESET;
        end else if (w_wr) begin
            case (paddr[2])
                srsw_pkg::REG_TOTAL_PACKETS: r_total_packets <= pwdata[srsw_pkg::CFG_BITS-1:0];
                srsw_pkg::REG_TIMEOUT_TICKS: r_timeout_ticks <= pwdata[srsw_pkg::CFG_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            srsw_pkg::REG_TOTAL_PACKETS:
                prdata = srsw_pkg::APB_DATA_BITS'(r_total_packets);
            srsw_pkg::REG_TIMEOUT_TICKS:
                prdata = srsw_pkg::APB_DATA_BITS'(r_timeout_ticks);
            default: prdata = '0;
        endcase
    end

    assign o_total_packets = r_total_packets;
    assign o_timeout_ticks = r_timeout_ticks;

endmodule

// ===== rtl/core/srsw_ctrl.sv =====
// Controller FSM: sequences send, ack/slide and tick work on the datapath.
// Depends on srsw_pkg.
module srsw_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic [1:0]           i_opcode,
    input  srsw_pkg::t_dp_status i_status,
    output logic                 o_in_ready,
    output srsw_pkg::t_dp_op     o_dp_op
);

    srsw_pkg::t_state r_state;
    srsw_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srsw_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            srsw_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_opcode)
                        srsw_pkg::OP_SEND: n_state = srsw_pkg::ST_SEND;
                        srsw_pkg::OP_ACK:  n_state = srsw_pkg::ST_ACK_CHECK;
                        srsw_pkg::OP_TICK: n_state = srsw_pkg::ST_TICK_START;
                        default:           n_state = srsw_pkg::ST_RESULT;
                    endcase
                end
            end
            srsw_pkg::ST_SEND: n_state = srsw_pkg::ST_RESULT;
            srsw_pkg::ST_ACK_CHECK: begin
                if (i_status.done) begin
                    n_state = srsw_pkg::ST_RESULT;
                end else if (i_status.in_range) begin
                    n_state = srsw_pkg::ST_ACK_MARK;
                end else begin
                    n_state = srsw_pkg::ST_ACK_FIN;
                end
            end
            srsw_pkg::ST_ACK_MARK: n_state = srsw_pkg::ST_SLIDE;
            srsw_pkg::ST_SLIDE: begin
                if (!i_status.slide_more) begin
                    n_state = srsw_pkg::ST_ACK_FIN;
                end
            end
            srsw_pkg::ST_ACK_FIN: n_state = srsw_pkg::ST_RESULT;
            srsw_pkg::ST_TICK_START: begin
                n_state = i_status.tick_go ? srsw_pkg::ST_TICK_EVAL : srsw_pkg::ST_RESULT;
            end
            srsw_pkg::ST_TICK_EVAL: n_state = srsw_pkg::ST_TICK_DROP;
            srsw_pkg::ST_TICK_DROP: n_state = srsw_pkg::ST_RESULT;
            srsw_pkg::ST_RESULT: begin
                if (i_status.out_free) begin
                    n_state = srsw_pkg::ST_IDLE;
                end
            end
            default: n_state = srsw_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_dp_op    = srsw_pkg::DP_NOP;
        case (r_state)
            srsw_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_dp_op = srsw_pkg::DP_LOAD;
                end
            end
            srsw_pkg::ST_SEND:       o_dp_op = srsw_pkg::DP_SEND;
            srsw_pkg::ST_ACK_MARK:   o_dp_op = srsw_pkg::DP_ACK_MARK;
            srsw_pkg::ST_SLIDE:      o_dp_op = srsw_pkg::DP_SLIDE;
            srsw_pkg::ST_ACK_FIN:    o_dp_op = srsw_pkg::DP_ACK_FIN;
            srsw_pkg::ST_TICK_START: o_dp_op = srsw_pkg::DP_TICK_START;
            srsw_pkg::ST_TICK_EVAL:  o_dp_op = srsw_pkg::DP_TICK_EVAL;
            srsw_pkg::ST_TICK_DROP:  o_dp_op = srsw_pkg::DP_TICK_DROP;
            srsw_pkg::ST_RESULT: begin
                if (i_status.out_free) begin
                    o_dp_op = srsw_pkg::DP_EMIT;
                end
            end
            default: o_dp_op = srsw_pkg::DP_NOP;
        endcase
    end

endmodule

// ===== rtl/core/srsw_dp.sv =====
// Datapath: window slot flags, timeout queue memory, pointers and result register.
// Depends on srsw_pkg and srsw_out_if; driven by srsw_ctrl commands.
module srsw_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  srsw_pkg::t_dp_op              i_dp_op,
    input  logic [1:0]                    i_opcode,
    input  logic [srsw_pkg::SEQ_BITS-1:0] i_ack_seq,
    input  logic [srsw_pkg::CFG_BITS-1:0] i_total_packets,
    input  logic [srsw_pkg::CFG_BITS-1:0] i_timeout_ticks,
    output srsw_pkg::t_dp_status          o_status,
    srsw_out_if.source                    o_rsp
);

    localparam int W  = srsw_pkg::WINDOW_SIZE;
    localparam int SB = srsw_pkg::SLOT_BITS;
    localparam int PB = srsw_pkg::PTR_BITS;
    localparam int CB = srsw_pkg::CNT_BITS;
    localparam int QB = srsw_pkg::SEQ_BITS;
    localparam int TB = srsw_pkg::TIME_BITS;

    // control state
    logic [W-1:0]  r_acked;      // slot acked flag; clear means empty or sent
    logic [W-1:0]  r_q_acked;
    logic [QB-1:0] r_next;
    logic [QB-1:0] r_base;
    logic [CB-1:0] r_free;
    logic [PB-1:0] r_head;
    logic [PB-1:0] r_tail;
    logic [TB-1:0] r_now;
    logic          r_done;
    logic [CB-1:0] r_slide_n;
    logic          r_out_valid;

    // payload
    logic [SB-1:0]           r_qpos [W];
    srsw_pkg::t_q_entry      r_q_mem [W];
    srsw_pkg::t_q_entry      r_rd_entry;
    logic [QB-1:0]           r_ack;
    srsw_pkg::t_result_kind  r_kind;
    logic [QB-1:0]           r_pseq;
    srsw_pkg::t_result_kind  r_out_kind;
    logic [QB-1:0]           r_out_pseq;
    logic [QB-1:0]           r_out_base;
    logic [CB-1:0]           r_out_free;
    logic                    r_out_done;

    logic [PB-1:0] w_fill;
    logic          w_nonempty;
    logic          w_full;
    logic [SB-1:0] w_head_slot;
    logic [SB-1:0] w_tail_slot;
    logic [SB-1:0] w_next_slot;
    logic [SB-1:0] w_ack_slot;
    logic [SB-1:0] w_base_slot;
    logic [SB-1:0] w_slot_addr;
    logic          w_slot_acked;
    logic          w_send_ok;
    logic          w_in_range;
    logic          w_slide_more;
    logic [TB-1:0] w_age;
    logic          w_expired;
    logic          w_drop;

    assign w_fill      = r_tail - r_head;
    assign w_nonempty  = (r_tail != r_head);
    assign w_full      = (w_fill == PB'(W));
    assign w_head_slot = r_head[SB-1:0];
    assign w_tail_slot = r_tail[SB-1:0];
    assign w_next_slot = r_next[SB-1:0];
    assign w_ack_slot  = r_ack[SB-1:0];
    assign w_base_slot = r_base[SB-1:0];

    // single read port on the slot flags: ack slot while marking, base slot otherwise
    assign w_slot_addr  = (i_dp_op == srsw_pkg::DP_ACK_MARK) ? w_ack_slot : w_base_slot;
    assign w_slot_acked = r_acked[w_slot_addr];

    assign w_send_ok = !r_done && (r_free != '0) &&
                       (32'(r_next) < 32'(i_total_packets)) && !w_full;
    assign w_in_range   = (r_ack >= r_base) && (r_ack < r_next);
    assign w_slide_more = (r_base != r_next) && w_slot_acked && (r_slide_n < CB'(W));

    // age wraps with the tick counter
    assign w_age     = r_now - r_rd_entry.stamp;
    assign w_expired = !r_q_acked[w_head_slot] && (w_age >= TB'(i_timeout_ticks));
    assign w_drop    = w_nonempty && r_q_acked[w_head_slot];

    assign o_status.done       = r_done;
    assign o_status.in_range   = w_in_range;
    assign o_status.slide_more = w_slide_more;
    assign o_status.tick_go    = !r_done && w_nonempty;
    assign o_status.out_free   = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acked     <= '0;
            r_q_acked   <= '0;
            r_next      <= '0;
            r_base      <= '0;
            r_free      <= CB'(W);
            r_head      <= '0;
            r_tail      <= '0;
            r_now       <= '0;
            r_done      <= 1'b0;
            r_slide_n   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_dp_op == srsw_pkg::DP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_dp_op)
                srsw_pkg::DP_SEND: begin
                    if (w_send_ok) begin
                        r_acked[w_next_slot]   <= 1'b0;
                        r_q_acked[w_tail_slot] <= 1'b0;
                        r_tail                 <= r_tail + 1'b1;
                        r_next                 <= r_next + 1'b1;
                        r_free                 <= r_free - 1'b1;
                    end
                end
                srsw_pkg::DP_ACK_MARK: begin
                    r_slide_n <= '0;
                    if (!w_slot_acked) begin
                        r_acked[w_ack_slot]           <= 1'b1;
                        r_q_acked[r_qpos[w_ack_slot]] <= 1'b1;
                    end
                end
                srsw_pkg::DP_SLIDE: begin
                    if (w_slide_more) begin
                        r_acked[w_base_slot] <= 1'b0;
                        r_base               <= r_base + 1'b1;
                        r_free               <= r_free + 1'b1;
                        r_slide_n            <= r_slide_n + 1'b1;
                    end
                end
                srsw_pkg::DP_ACK_FIN: begin
                    if (32'(r_base) >= 32'(i_total_packets)) begin
                        r_done <= 1'b1;
                    end
                end
                srsw_pkg::DP_TICK_START: r_now <= r_now + 1'b1;
                srsw_pkg::DP_TICK_EVAL: begin
                    // expired head moves to the tail with a fresh stamp
                    if (w_expired) begin
                        r_head                 <= r_head + 1'b1;
                        r_tail                 <= r_tail + 1'b1;
                        r_q_acked[w_tail_slot] <= 1'b0;
                    end
                end
                srsw_pkg::DP_TICK_DROP: begin
                    if (w_drop) begin
                        r_head <= r_head + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // timeout queue memory: write at tail, registered read at head
    always_ff @(posedge i_clk) begin
        if (i_dp_op == srsw_pkg::DP_SEND && w_send_ok) begin
            r_q_mem[w_tail_slot] <= '{seq: r_next, stamp: r_now};
        end else if (i_dp_op == srsw_pkg::DP_TICK_EVAL && w_expired) begin
            r_q_mem[w_tail_slot] <= '{seq: r_rd_entry.seq, stamp: r_now};
        end
        if (i_dp_op == srsw_pkg::DP_TICK_START) begin
            r_rd_entry <= r_q_mem[w_head_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_dp_op)
            srsw_pkg::DP_LOAD: begin
                r_ack <= i_ack_seq;
                if (i_opcode == srsw_pkg::OP_ACK) begin
                    r_kind <= srsw_pkg::RK_ACK_IGNORED;
                    r_pseq <= i_ack_seq;
                end else begin
                    r_kind <= srsw_pkg::RK_NONE;
                    r_pseq <= '0;
                end
            end
            srsw_pkg::DP_SEND: begin
                if (w_send_ok) begin
                    r_kind              <= srsw_pkg::RK_SEND;
                    r_pseq              <= r_next;
                    r_qpos[w_next_slot] <= w_tail_slot;
                end
            end
            srsw_pkg::DP_ACK_MARK: begin
                if (!w_slot_acked) begin
                    r_kind <= srsw_pkg::RK_ACK_TAKEN;
                end
            end
            srsw_pkg::DP_TICK_EVAL: begin
                if (w_expired) begin
                    r_kind                           <= srsw_pkg::RK_RETX;
                    r_pseq                           <= r_rd_entry.seq;
                    r_qpos[r_rd_entry.seq[SB-1:0]]   <= w_tail_slot;
                end
            end
            srsw_pkg::DP_EMIT: begin
                r_out_kind <= r_kind;
                r_out_pseq <= r_pseq;
                r_out_base <= r_base;
                r_out_free <= r_free;
                r_out_done <= r_done;
            end
            default: ;
        endcase
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.result_kind = r_out_kind;
    assign o_rsp.packet_seq  = r_out_pseq;
    assign o_rsp.base_seq    = r_out_base;
    assign o_rsp.free_slots  = r_out_free;
    assign o_rsp.all_done    = r_out_done;

    a_free_tracks_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free == CB'(W) - CB'(QB'(r_next - r_base)))
        else $error("free count out of step with base and next sequence");

    a_queue_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fill <= PB'(W))
        else $error("timeout queue fill exceeds window");

    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> r_done)
        else $error("done flag dropped");

endmodule

// ===== rtl/core/selective_repeat_sender_window.sv =====
// Top level of the selective-repeat sender window: controller, datapath, APB regs.
// Depends on srsw_pkg, srsw_in_if, srsw_out_if, srsw_apb_regs, srsw_ctrl, srsw_dp.
//
// Usage:
//   i_req  : request beats (opcode 0 send, 1 ack with ack_seq, 2 tick).
//   o_rsp  : exactly one result beat per request, in request order.
//   APB    : total_packets at 0x0, timeout_ticks at 0x4; write only while idle.
// Controller states, from request accept to result valid (all end in RESULT):
//   send: SEND; tick: TICK_START, TICK_EVAL, TICK_DROP (TICK_START only when done
//   or queue empty); ack: ACK_CHECK, ACK_MARK, SLIDE while the base slides 0..16
//   slots, ACK_FIN; ack out of window: ACK_CHECK, ACK_FIN; after done: ACK_CHECK.
//   The ack slide, one slot per cycle through the slot flag read port, sets the
//   worst case. One request is in work at a time; the next is taken in the
//   cycle after its result is loaded into the output register.
// Reset (synchronous, active low): window empty, base and next sequence zero,
// tick count zero, queue empty, total_packets 0, timeout_ticks 6000.
// No clearing pass is needed. When o_rsp is stalled, the finished result holds
// in the output register and the block waits with the following result until
// the receiver takes it; i_req is still accepted while the block is idle.
module selective_repeat_sender_window (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    srsw_in_if.sink                             i_req,
    srsw_out_if.source                          o_rsp,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [srsw_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [srsw_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [srsw_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready
);

    logic [srsw_pkg::CFG_BITS-1:0] w_total_packets;
    logic [srsw_pkg::CFG_BITS-1:0] w_timeout_ticks;
    srsw_pkg::t_dp_status          w_status;
    srsw_pkg::t_dp_op              w_dp_op;
    logic                          w_in_ready;

    assign i_req.ready = w_in_ready;

    srsw_apb_regs u_regs (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_total_packets (w_total_packets),
        .o_timeout_ticks (w_timeout_ticks)
    );

    srsw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_opcode   (i_req.opcode),
        .i_status   (w_status),
        .o_in_ready (w_in_ready),
        .o_dp_op    (w_dp_op)
    );

    srsw_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_dp_op         (w_dp_op),
        .i_opcode        (i_req.opcode),
        .i_ack_seq       (i_req.ack_seq),
        .i_total_packets (w_total_packets),
        .i_timeout_ticks (w_timeout_ticks),
        .o_status        (w_status),
        .o_rsp           (o_rsp)
    );

endmodule

// ===== sim/selective_repeat_sender_window_tb.sv =====
// Self-checking testbench for the selective-repeat sender window.
// Depends on srsw_pkg, srsw_in_if, srsw_out_if and selective_repeat_sender_window.
`timescale 1ns / 1ps

module selective_repeat_sender_window_tb;

    typedef enum logic [1:0] {
        SLOT_EMPTY = 2'd0,
        SLOT_SENT  = 2'd2,
        SLOT_ACKED = 2'd3
    } t_slot_state;

    typedef struct {
        srsw_pkg::t_result_kind        kind;
        logic [srsw_pkg::SEQ_BITS-1:0] seq;
        logic [srsw_pkg::SEQ_BITS-1:0] base;
        logic [srsw_pkg::CNT_BITS-1:0] free;
        logic                          done;
    } t_window_result;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               psel;
    logic                               penable;
    logic                               pwrite;
    logic [srsw_pkg::APB_ADDR_BITS-1:0] paddr;
    logic [srsw_pkg::APB_DATA_BITS-1:0] pwdata;
    logic [srsw_pkg::APB_DATA_BITS-1:0] prdata;
    logic                               pready;

    srsw_in_if  req_if ();
    srsw_out_if rsp_if ();

    selective_repeat_sender_window u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // window predictor state
    logic [srsw_pkg::CFG_BITS-1:0]  total_cfg;
    logic [srsw_pkg::CFG_BITS-1:0]  timeout_cfg;
    t_slot_state                    slot_state [srsw_pkg::WINDOW_SIZE];
    logic [srsw_pkg::SLOT_BITS-1:0] slot_qpos  [srsw_pkg::WINDOW_SIZE];
    logic [srsw_pkg::SEQ_BITS-1:0]  q_seq      [srsw_pkg::WINDOW_SIZE];
    logic [srsw_pkg::TIME_BITS-1:0] q_stamp    [srsw_pkg::WINDOW_SIZE];
    logic                           q_acked    [srsw_pkg::WINDOW_SIZE];
    logic [srsw_pkg::PTR_BITS-1:0]  q_head;
    logic [srsw_pkg::PTR_BITS-1:0]  q_tail;
    logic [srsw_pkg::SEQ_BITS-1:0]  w_next;
    logic [srsw_pkg::SEQ_BITS-1:0]  w_base;
    logic [srsw_pkg::CNT_BITS-1:0]  w_free;
    logic [srsw_pkg::TIME_BITS-1:0] w_now;
    logic                           w_done;

    t_window_result pending_results [$];
    bit             idling_on;
    int             mismatches;
    int             beats_checked;
    int             kind_seen [5];

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d results outstanding", pending_results.size());
        $display("Mismatches found");
        $finish;
    end

    function automatic logic [srsw_pkg::SLOT_BITS-1:0] enqueue_stamp(
        input logic [srsw_pkg::SEQ_BITS-1:0] seq);
        logic [srsw_pkg::SLOT_BITS-1:0] t;
        t = q_tail[srsw_pkg::SLOT_BITS-1:0];
        q_seq[t]   = seq;
        q_stamp[t] = w_now;
        q_acked[t] = 1'b0;
        q_tail     = q_tail + 1'b1;
        return t;
    endfunction

    function automatic t_window_result advance_window(input logic [1:0] op,
                                                      input logic [srsw_pkg::SEQ_BITS-1:0] ack);
        t_window_result                 r;
        logic [srsw_pkg::SLOT_BITS-1:0] s;
        logic [srsw_pkg::SLOT_BITS-1:0] h;
        logic [srsw_pkg::PTR_BITS-1:0]  fill;
        logic [srsw_pkg::TIME_BITS-1:0] age;
        logic [srsw_pkg::SEQ_BITS-1:0]  rseq;
        int                             n;
        r.kind = srsw_pkg::RK_NONE;
        r.seq  = '0;
        case (op)
            srsw_pkg::OP_SEND: begin
                fill = q_tail - q_head;
                if (!w_done && w_free > 0 && w_next < total_cfg &&
                    fill < srsw_pkg::WINDOW_SIZE) begin
                    s = w_next[srsw_pkg::SLOT_BITS-1:0];
                    slot_state[s] = SLOT_SENT;
                    slot_qpos[s]  = enqueue_stamp(w_next);
                    r.kind = srsw_pkg::RK_SEND;
                    r.seq  = w_next;
                    w_next = w_next + 1'b1;
                    w_free = w_free - 1'b1;
                end
            end
            srsw_pkg::OP_ACK: begin
                r.kind = srsw_pkg::RK_ACK_IGNORED;
                r.seq  = ack;
                if (!w_done) begin
                    if (ack >= w_base && ack < w_next) begin
                        s = ack[srsw_pkg::SLOT_BITS-1:0];
                        if (slot_state[s] != SLOT_ACKED) begin
                            slot_state[s] = SLOT_ACKED;
                            q_acked[slot_qpos[s]] = 1'b1;
                            r.kind = srsw_pkg::RK_ACK_TAKEN;
                        end
                        n = 0;
                        while (n < srsw_pkg::WINDOW_SIZE && w_base != w_next &&
                               slot_state[w_base[srsw_pkg::SLOT_BITS-1:0]] == SLOT_ACKED) begin
                            slot_state[w_base[srsw_pkg::SLOT_BITS-1:0]] = SLOT_EMPTY;
                            w_base = w_base + 1'b1;
                            w_free = w_free + 1'b1;
                            n++;
                        end
                    end
                    if (w_base >= total_cfg)
                        w_done = 1'b1;
                end
            end
            srsw_pkg::OP_TICK: begin
                w_now = w_now + 1'b1;
                fill  = q_tail - q_head;
                if (!w_done && fill != 0) begin
                    h   = q_head[srsw_pkg::SLOT_BITS-1:0];
                    age = w_now - q_stamp[h];
                    if (!q_acked[h] && age >= timeout_cfg) begin
                        rseq   = q_seq[h];
                        q_head = q_head + 1'b1;
                        slot_qpos[rseq[srsw_pkg::SLOT_BITS-1:0]] = enqueue_stamp(rseq);
                        r.kind = srsw_pkg::RK_RETX;
                        r.seq  = rseq;
                    end
                    // an acked entry at the head is retired on the same tick
                    fill = q_tail - q_head;
                    if (fill != 0 && q_acked[q_head[srsw_pkg::SLOT_BITS-1:0]])
                        q_head = q_head + 1'b1;
                end
            end
            default: ;
        endcase
        r.base = w_base;
        r.free = w_free;
        r.done = w_done;
        return r;
    endfunction

    // caller is at a falling edge; valid stays high unless a gap is drawn
    task automatic issue_request(input logic [1:0] op,
                                 input logic [srsw_pkg::SEQ_BITS-1:0] ack);
        req_if.valid   = 1'b1;
        req_if.opcode  = op;
        req_if.ack_seq = ack;
        @(posedge i_clk);
        while (!req_if.ready)
            @(posedge i_clk);
        pending_results.push_back(advance_window(op, ack));
        @(negedge i_clk);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            req_if.valid = 1'b0;
            repeat ($urandom_range(1, 11))
                @(negedge i_clk);
        end
    endtask

    task automatic drain_results();
        req_if.valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (40)
            @(negedge i_clk);
    endtask

    task automatic write_reg(input logic sel, input logic [srsw_pkg::CFG_BITS-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {sel, 2'b00};
        pwdata  = {{(srsw_pkg::APB_DATA_BITS - srsw_pkg::CFG_BITS){1'b0}}, value};
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        if (sel == srsw_pkg::REG_TOTAL_PACKETS)
            total_cfg = value;
        else
            timeout_cfg = value;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    function automatic void note_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s", $realtime, what);
    endfunction

    always @(posedge i_clk) begin
        t_window_result exp;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            beats_checked++;
            if (rsp_if.result_kind < 5)
                kind_seen[rsp_if.result_kind]++;
            if (pending_results.size() == 0) begin
                note_mismatch($sformatf("result beat with nothing expected: kind %0d seq %0d",
                                        rsp_if.result_kind, rsp_if.packet_seq));
            end else begin
                exp = pending_results.pop_front();
                if (rsp_if.result_kind !== exp.kind || rsp_if.packet_seq !== exp.seq ||
                    rsp_if.base_seq !== exp.base || rsp_if.free_slots !== exp.free ||
                    rsp_if.all_done !== exp.done)
                    note_mismatch({
                        $sformatf("beat %0d exp kind %0d seq %0d base %0d free %0d done %0d",
                                  beats_checked, exp.kind, exp.seq, exp.base, exp.free,
                                  exp.done),
                        $sformatf(", got %0d %0d %0d %0d %0d", rsp_if.result_kind,
                                  rsp_if.packet_seq, rsp_if.base_seq, rsp_if.free_slots,
                                  rsp_if.all_done)});
            end
        end
    end

    // receiver stalls in bursts while idling is on
    initial begin
        rsp_if.ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (idling_on && $urandom_range(0, 5) == 0) begin
                rsp_if.ready = 1'b0;
                repeat ($urandom_range(1, 11))
                    @(negedge i_clk);
                rsp_if.ready = 1'b1;
            end
        end
    end

    // nothing configured yet: sends are refused, ticks only count time
    task automatic test_before_setup();
        issue_request(srsw_pkg::OP_SEND, 16'd0);
        issue_request(srsw_pkg::OP_TICK, 16'hFFFF);
        issue_request(srsw_pkg::OP_SEND, 16'hFFFF);
        issue_request(srsw_pkg::OP_TICK, 16'd0);
        issue_request(2'd3, 16'd0);
        drain_results();
    endtask

    task automatic test_window_directed();
        write_reg(srsw_pkg::REG_TOTAL_PACKETS, 16'd40);
        write_reg(srsw_pkg::REG_TIMEOUT_TICKS, 16'd3);
        // fill the window, the last send is refused
        for (int i = 0; i <= srsw_pkg::WINDOW_SIZE; i++)
            issue_request(srsw_pkg::OP_SEND, 16'd0);
        issue_request(srsw_pkg::OP_ACK, 16'd16);
        issue_request(srsw_pkg::OP_ACK, 16'hFFFF);
        issue_request(srsw_pkg::OP_ACK, 16'd5);
        issue_request(srsw_pkg::OP_ACK, 16'd5);
        issue_request(srsw_pkg::OP_ACK, 16'd0);
        repeat (3)
            issue_request(srsw_pkg::OP_TICK, 16'd0);
        issue_request(2'd3, 16'hFFFF);
        drain_results();
    endtask

    task automatic random_item();
        int pick;
        int k;
        logic [srsw_pkg::SEQ_BITS-1:0] ack;
        pick = $urandom_range(0, 99);
        if (pick < 28) begin
            issue_request(srsw_pkg::OP_SEND, 16'($urandom));
        end else if (pick < 60) begin
            if (w_next != w_base)
                ack = 16'($urandom_range(int'(w_next) - 1, int'(w_base)));
            else
                ack = w_base;
            issue_request(srsw_pkg::OP_ACK, ack);
        end else if (pick < 86) begin
            issue_request(srsw_pkg::OP_TICK, 16'($urandom));
        end else if (pick < 93) begin
            issue_request(srsw_pkg::OP_ACK, 16'($urandom_range(0, 65535)));
        end else if (pick < 97) begin
            k = $urandom_range(0, 2);
            ack = (k == 0) ? w_base - 1'b1 : (k == 1) ? w_next : w_next + 1'b1;
            issue_request(srsw_pkg::OP_ACK, ack);
        end else begin
            issue_request(2'd3, 16'($urandom));
        end
    endtask

    task automatic test_random_traffic();
        logic [srsw_pkg::CFG_BITS-1:0] timeouts [6];
        timeouts = '{16'd1, 16'd0, 16'hFFFF, 16'($urandom_range(2, 20)), 16'd3,
                     16'($urandom_range(2, 60))};
        write_reg(srsw_pkg::REG_TOTAL_PACKETS, 16'hFFFF);
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(srsw_pkg::REG_TIMEOUT_TICKS, timeouts[ph]);
            // phase 1 and the closing phase run without idling
            idling_on = (ph != 1 && ph != 5);
            repeat (115)
                random_item();
            drain_results();
        end
        idling_on = 1'b0;
    endtask

    // cap the transfer at what has been sent, ack it out, then poke the done state
    task automatic test_completion();
        write_reg(srsw_pkg::REG_TOTAL_PACKETS, w_next);
        write_reg(srsw_pkg::REG_TIMEOUT_TICKS, 16'd2);
        issue_request(srsw_pkg::OP_SEND, 16'd0);
        while (!w_done) begin
            if ($urandom_range(0, 3) == 0)
                issue_request(srsw_pkg::OP_TICK, 16'd0);
            else if (w_next != w_base)
                issue_request(srsw_pkg::OP_ACK,
                              16'($urandom_range(int'(w_next) - 1, int'(w_base))));
            else
                issue_request(srsw_pkg::OP_ACK, w_base);
        end
        issue_request(srsw_pkg::OP_SEND, 16'd0);
        issue_request(srsw_pkg::OP_ACK, w_base - 1'b1);
        issue_request(srsw_pkg::OP_TICK, 16'd0);
        issue_request(srsw_pkg::OP_TICK, 16'd0);
        issue_request(2'd3, 16'd0);
        drain_results();
    endtask

    initial begin
        req_if.valid   = 1'b0;
        req_if.opcode  = srsw_pkg::OP_SEND;
        req_if.ack_seq = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        i_rst_n        = 1'b0;
        idling_on      = 1'b0;
        mismatches     = 0;
        beats_checked  = 0;
        kind_seen      = '{default: 0};
        total_cfg      = '0;
        timeout_cfg    = srsw_pkg::TIMEOUT_RESET;
        for (int i = 0; i < srsw_pkg::WINDOW_SIZE; i++) begin
            slot_state[i] = SLOT_EMPTY;
            slot_qpos[i]  = '0;
            q_seq[i]      = '0;
            q_stamp[i]    = '0;
            q_acked[i]    = 1'b0;
        end
        q_head = '0;
        q_tail = '0;
        w_next = '0;
        w_base = '0;
        w_free = srsw_pkg::CNT_BITS'(srsw_pkg::WINDOW_SIZE);
        w_now  = '0;
        w_done = 1'b0;

        repeat (11)
            @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_before_setup();
        test_window_directed();
        test_random_traffic();
        test_completion();

        $display("Checked %0d result beats: %0d sends, %0d retransmits, %0d acks taken,",
                 beats_checked, kind_seen[srsw_pkg::RK_SEND], kind_seen[srsw_pkg::RK_RETX],
                 kind_seen[srsw_pkg::RK_ACK_TAKEN]);
        $display("  %0d acks ignored, %0d no-op results; transfer completed at base %0d",
                 kind_seen[srsw_pkg::RK_ACK_IGNORED], kind_seen[srsw_pkg::RK_NONE], w_base);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
